[hdl/dqs_pkg.sv]
// Shared types, codes and defaults for the double-ended queue with search.
`default_nettype none

package dqs_pkg;

  // Default configuration
  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed payload widths on the channels
  localparam int REQ_W          = 3;
  localparam int ITEM_W         = 32;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_COUNT_W  = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_FIND       = 3'd6,
    REQ_REMOVE     = 3'd7
  } req_code_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_code_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } fsm_state_t;

  // What a cell does with its word at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  // Per-cell control bundle
  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage : dqs_pkg

`default_nettype wire

[hdl/dqs_if.sv]
// Request and response channel interfaces (valid/ready with payload).
`default_nettype none

interface dqs_req_if;
  import dqs_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface : dqs_req_if

interface dqs_rsp_if;
  import dqs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ITEM_W-1:0]        result_value;
  logic [STATUS_W-1:0]      status;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  output ready);
endinterface : dqs_rsp_if

`default_nettype wire

[hdl/dqs_cell.sv]
// One storage cell of the queue: holds a word, shifts with its neighbors, compares to a key.
`default_nettype none

module dqs_cell #(
  parameter int WORD_WIDTH = dqs_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire dqs_pkg::cell_ctrl_t    ctrl,
  input  wire logic [WORD_WIDTH-1:0]  left_word,
  input  wire logic [WORD_WIDTH-1:0]  right_word,
  input  wire logic [WORD_WIDTH-1:0]  load_word,
  input  wire logic [WORD_WIDTH-1:0]  cmp_key,
  output logic      [WORD_WIDTH-1:0]  word,
  output logic                        match
);
  import dqs_pkg::*;

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;
  logic                  match_r;

  // Word select
  always_comb begin
    case (ctrl.op)
      CELL_HOLD:       word_nxt = word_r;
      CELL_TAKE_LEFT:  word_nxt = left_word;
      CELL_TAKE_RIGHT: word_nxt = right_word;
      CELL_LOAD:       word_nxt = load_word;
      default:         word_nxt = word_r;
    endcase
  end

  // Word storage and registered equality check
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (ctrl.cmp_en) begin
      match_r <= (word_r == cmp_key);
    end
  end

  assign word  = word_r;
  assign match = match_r;

endmodule : dqs_cell

`default_nettype wire

[hdl/double_ended_queue_with_search.sv]
// Top level: bounded double-ended queue with find and remove, built as a row of cells.
//
//   channel  | dir | transfer fields
//   ---------+-----+------------------------------------------------
//   in_ch    | in  | req_type[2:0], item_value[31:0]
//   out_ch   | out | result_value[31:0], status[1:0], entry_count[4:0]
//
// At the input transfer every cell compares its word to the key and registers
// the result; the apply state then resolves the first match, shifts the cell
// row and loads the output register.
// A stalled output holds the apply cycle; a waiting result does not block the next input.
// Reset (synchronous, active low) empties the queue at once; cell words are not cleared.
`default_nettype none

module double_ended_queue_with_search #(
  parameter int DEPTH      = dqs_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = dqs_pkg::WORD_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dqs_req_if.sink    in_ch,
  dqs_rsp_if.source  out_ch
);
  import dqs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer
  fsm_state_t state_r;
  fsm_state_t state_nxt;
  logic       in_ready;
  logic       apply_en;
  logic       in_xfer;
  logic       fire;

  // Request holding
  req_code_t             req_r;
  logic [WORD_WIDTH-1:0] key_r;
  logic [WORD_WIDTH-1:0] cmp_key;

  // Queue state
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // Cell row
  logic [DEPTH-1:0][WORD_WIDTH-1:0] words;
  logic [DEPTH-1:0][WORD_WIDTH-1:0] left_words;
  logic [DEPTH-1:0][WORD_WIDTH-1:0] right_words;
  logic [DEPTH-1:0]                 match;
  cell_ctrl_t                       ctrl [DEPTH];

  // Apply-cycle decode
  logic [DEPTH-1:0]      occ;
  logic [DEPTH-1:0]      back_sel;
  logic [DEPTH-1:0]      push_sel;
  logic [DEPTH-1:0]      hit;
  logic [DEPTH-1:0]      first_hit;
  logic [DEPTH-1:0]      at_or_after;
  logic                  found;
  logic                  empty;
  logic                  full;
  logic [WORD_WIDTH-1:0] front_word;
  logic [WORD_WIDTH-1:0] back_word;
  logic [WORD_WIDTH-1:0] found_word;
  logic [WORD_WIDTH-1:0] res_word;
  stat_code_t            res_stat;
  cell_op_t              row_op [DEPTH];

  // Output register
  logic                     out_valid_r;
  logic [ITEM_W-1:0]        result_r;
  stat_code_t               status_r;
  logic [ENTRY_COUNT_W-1:0] entry_count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_APPLY;
      ST_APPLY: if (fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    apply_en = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_APPLY: apply_en = 1'b1;
      default:  in_ready = 1'b0;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_xfer     = in_ch.valid && in_ready;
  assign fire        = apply_en && (!out_valid_r || out_ch.ready);
  assign cmp_key     = WORD_WIDTH'(in_ch.item_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request at the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= req_code_t'(in_ch.req_type);
      key_r <= cmp_key;
    end
  end

  // Neighbor wiring: cell 0 takes the pushed word from the left, last cell takes zero
  assign left_words  = {words[DEPTH-2:0], key_r};
  assign right_words = {{WORD_WIDTH{1'b0}}, words[DEPTH-1:1]};

  // Occupancy and position decode
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]      = (CW'(i) < count_r);
      push_sel[i] = (CW'(i) == count_r);
    end
  end

  assign back_sel    = occ & ~(occ >> 1);
  assign hit         = match & occ;
  assign first_hit   = hit & (~hit + DEPTH'(1));
  assign at_or_after = ~(first_hit - DEPTH'(1));
  assign found       = |hit;
  assign empty       = (count_r == '0);
  assign full        = (count_r == CW'(DEPTH));
  assign front_word  = words[0];

  // One-hot word selects
  always_comb begin
    back_word  = '0;
    found_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word  = back_word  | (back_sel[i]  ? words[i] : '0);
      found_word = found_word | (first_hit[i] ? words[i] : '0);
    end
  end

  // Request decode: row shifts, count update and result
  always_comb begin
    count_nxt = count_r;
    res_word  = '0;
    res_stat  = STAT_OK;
    for (int i = 0; i < DEPTH; i++) begin
      row_op[i] = CELL_HOLD;
    end
    case (req_r)
      REQ_PUSH_FRONT: begin
        if (full) begin
          res_stat = STAT_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) row_op[i] = CELL_TAKE_LEFT;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          res_stat = STAT_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) row_op[i] = push_sel[i] ? CELL_LOAD : CELL_HOLD;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          res_stat = STAT_EMPTY;
        end else begin
          res_word = front_word;
          for (int i = 0; i < DEPTH; i++) row_op[i] = CELL_TAKE_RIGHT;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          res_stat = STAT_EMPTY;
        end else begin
          res_word  = back_word;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) res_stat = STAT_EMPTY;
        else       res_word = front_word;
      end
      REQ_PEEK_BACK: begin
        if (empty) res_stat = STAT_EMPTY;
        else       res_word = back_word;
      end
      REQ_FIND: begin
        if (!found) res_stat = STAT_NOT_FOUND;
        else        res_word = found_word;
      end
      REQ_REMOVE: begin
        if (!found) begin
          res_stat = STAT_NOT_FOUND;
        end else begin
          res_word = found_word;
          for (int i = 0; i < DEPTH; i++) begin
            row_op[i] = at_or_after[i] ? CELL_TAKE_RIGHT : CELL_HOLD;
          end
          count_nxt = count_r - CW'(1);
        end
      end
      default: res_stat = STAT_OK;
    endcase
  end

  // Cell controls: compare on input transfer, shift only on the apply edge
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].cmp_en = in_xfer;
      ctrl[i].op     = fire ? row_op[i] : CELL_HOLD;
    end
  end

  // Cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dqs_cell #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .left_word  (left_words[g]),
      .right_word (right_words[g]),
      .load_word  (key_r),
      .cmp_key    (cmp_key),
      .word       (words[g]),
      .match      (match[g])
    );
  end

  // Count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r      <= ITEM_W'(res_word);
      status_r      <= res_stat;
      entry_count_r <= ENTRY_COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = result_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = entry_count_r;

endmodule : double_ended_queue_with_search

`default_nettype wire

[hdl/dqs_chk.sv]
// Port-level checks for the queue, bound to the top level.
`default_nettype none

module dqs_chk #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [dqs_pkg::ITEM_W-1:0]        out_result,
  input wire logic [dqs_pkg::STATUS_W-1:0]      out_status,
  input wire logic [dqs_pkg::ENTRY_COUNT_W-1:0] out_count
);
  import dqs_pkg::*;

  // One request in flight: no new transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result) &&
                                   $stable(out_status) && $stable(out_count)))
    else $error("stalled result changed");

  // Full status only with a full queue
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (out_count == ENTRY_COUNT_W'(DEPTH)))
    else $error("full status with queue not full");

  // Empty status only with an empty queue, and empty, not-found and full carry no word
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_count == '0 && out_result == '0))
    else $error("empty status with stored words or a word");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_NOT_FOUND || out_status == STAT_FULL))
      |-> (out_result == '0))
    else $error("failed request returned a word");

endmodule : dqs_chk

bind double_ended_queue_with_search dqs_chk #(
  .DEPTH (DEPTH)
) u_dqs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_value),
  .out_status (out_ch.status),
  .out_count  (out_ch.entry_count)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the double-ended queue with search: mirrored deque, directed and random traffic.
`timescale 1ns / 1ps

module tb;
  import dqs_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_LEN = 60;

  // Traffic mixes for the random part
  typedef enum int {
    MIX_EVEN,
    MIX_FILL,
    MIX_DRAIN,
    MIX_SEARCH
  } mix_t;

  typedef struct {
    logic [ITEM_W-1:0]        value;
    stat_code_t               status;
    logic [ENTRY_COUNT_W-1:0] count;
  } answer_t;

  // Mirror of the deque plus the answers still owed by the block
  class deque_tracker;
    logic [ITEM_W-1:0] words[$];
    answer_t           owed[$];
    int                errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted request to the mirror and queue its answer
    function void note_request(req_code_t req, logic [ITEM_W-1:0] key);
      answer_t ans;
      int      pos;
      ans.value  = '0;
      ans.status = STAT_OK;
      pos        = -1;
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (words.size() >= QUEUE_DEPTH) begin
            ans.status = STAT_FULL;
          end else if (req == REQ_PUSH_FRONT) begin
            words.push_front(key);
          end else begin
            words.push_back(key);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
          if (words.size() == 0) begin
            ans.status = STAT_EMPTY;
          end else if (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT) begin
            ans.value = words[0];
            if (req == REQ_POP_FRONT) void'(words.pop_front());
          end else begin
            ans.value = words[words.size()-1];
            if (req == REQ_POP_BACK) void'(words.pop_back());
          end
        end
        default: begin
          // find / remove: first equal word from the front
          for (int i = 0; i < words.size(); i++) begin
            if (pos < 0 && words[i] == key) pos = i;
          end
          if (pos < 0) begin
            ans.status = STAT_NOT_FOUND;
          end else begin
            ans.value = words[pos];
            if (req == REQ_REMOVE) words.delete(pos);
          end
        end
      endcase
      ans.count = ENTRY_COUNT_W'(words.size());
      owed.push_back(ans);
    endfunction

    // Compare one result transfer against the oldest owed answer
    function void check_answer(logic [ITEM_W-1:0] value, logic [STATUS_W-1:0] status,
                               logic [ENTRY_COUNT_W-1:0] count);
      answer_t ans;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: value=%h status=%0d count=%0d",
                 $time, value, status, count);
        return;
      end
      ans = owed.pop_front();
      if (value !== ans.value) begin
        errors++;
        $display("%0t: result_value mismatch: expected %h actual %h", $time, ans.value, value);
      end
      if (status !== ans.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, ans.status, status);
      end
      if (count !== ans.count) begin
        errors++;
        $display("%0t: entry_count mismatch: expected %0d actual %0d", $time, ans.count, count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  bit   req_burst = 1'b0;
  bit   rsp_burst = 1'b0;
  logic [ITEM_W-1:0] key_pool[8];
  deque_tracker tracker;

  dqs_req_if in_ch();
  dqs_rsp_if out_ch();

  double_ended_queue_with_search uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Watch both channels; results are checked before the new request is noted
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_answer(out_ch.result_value, out_ch.status, out_ch.entry_count);
      if (in_ch.valid && in_ch.ready)
        tracker.note_request(req_code_t'(in_ch.req_type), in_ch.item_value);
    end
  end

  // Result side: random stall before each transfer
  initial begin : rsp_drive
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = rsp_burst ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One request transfer, after a random gap
  task automatic send_req(req_code_t req, logic [ITEM_W-1:0] key);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.item_value <= key;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the sender off until every owed answer has arrived
  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // Mostly pooled keys so finds hit and duplicates occur
  function automatic logic [ITEM_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic req_code_t pick_req(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        if (r < 65) return req_code_t'($urandom_range(REQ_PUSH_FRONT, REQ_PUSH_BACK));
      MIX_DRAIN:
        if (r < 60) return req_code_t'($urandom_range(REQ_POP_FRONT, REQ_POP_BACK));
      MIX_SEARCH:
        if (r < 60) return req_code_t'($urandom_range(REQ_FIND, REQ_REMOVE));
      default: ;
    endcase
    return req_code_t'($urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    mix_t mix;
    tracker = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_PUSH_FRONT;
    in_ch.item_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue on every read-type request
    send_req(REQ_POP_FRONT, $urandom());
    send_req(REQ_POP_BACK, $urandom());
    send_req(REQ_PEEK_FRONT, $urandom());
    send_req(REQ_PEEK_BACK, $urandom());
    send_req(REQ_FIND, '0);
    send_req(REQ_REMOVE, '0);
    // Extreme words, duplicate, first-match remove, miss
    send_req(REQ_PUSH_BACK, '0);
    send_req(REQ_PUSH_FRONT, '1);
    send_req(REQ_PUSH_BACK, '0);
    send_req(REQ_PEEK_FRONT, $urandom());
    send_req(REQ_PEEK_BACK, $urandom());
    send_req(REQ_REMOVE, '0);
    send_req(REQ_FIND, '0);
    send_req(REQ_FIND, 32'hA5A5_5A5A);
    send_req(REQ_REMOVE, '1);
    send_req(REQ_POP_BACK, $urandom());
    send_req(REQ_POP_FRONT, $urandom());

    // Random part: phases of fill, drain, search and even traffic
    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        if (n > 0) mix = mix_t'($urandom_range(MIX_EVEN, MIX_SEARCH));
        req_burst = ($urandom_range(0, 3) == 0);
        rsp_burst = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) drain_answers();
      send_req(pick_req(mix), pick_key());
    end

    // Wind down: let the last transfer be noted before waiting on answers
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
